// ===== rtl/se2ta_pkg.sv =====
// se2ta_pkg: shared types, constants and helpers for the SE(2) transform block.
// Used by the stream interfaces, the CORDIC unit and the top level.
// No dependencies.
package se2ta_pkg;

    // Field and datapath widths
    localparam int FIELD_W  = 32;  // width of every coordinate field on the ports
    localparam int ANGLE_W  = 32;  // angle register, Q3.29
    localparam int TRIG_W   = 32;  // sine and cosine, Q2.30
    localparam int PROD_W   = 64;  // one coordinate times sine, cosine or offset
    localparam int ACC_W    = 66;  // rotated term plus offset, with headroom
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 2;

    // CORDIC widths
    localparam int Z_W      = 34;  // residual angle, Q.30 with headroom
    localparam int XY_W     = 34;  // CORDIC vector components
    localparam int STEP_W   = 5;   // index into the arctangent table
    localparam int ATAN_N   = 32;

    // Parameter defaults
    localparam int DEF_COORD_WIDTH  = 32;
    localparam int DEF_CORDIC_STEPS = 24;

    // Opcodes
    localparam logic [OP_W-1:0] OP_POINT    = 2'd0;
    localparam logic [OP_W-1:0] OP_VECTOR   = 2'd1;
    localparam logic [OP_W-1:0] OP_TWIST    = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_ANGLE    = 2'd0;
    localparam logic [INDEX_W-1:0] REG_OFFSET_X = 2'd1;
    localparam logic [INDEX_W-1:0] REG_OFFSET_Y = 2'd2;

    // Angle constants, Q.30
    localparam logic signed [Z_W-1:0]  Q30_PI      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0]  Q30_HALF_PI = 34'sd1686629713;
    // Start vector: inverse CORDIC gain at Q.30
    localparam logic signed [XY_W-1:0] CORDIC_START = 34'sd652032874;
    // Cosine of zero, Q2.30
    localparam logic signed [TRIG_W-1:0] COS_ONE = 32'sd1073741824;

    // Rounding bias for the final shift down to Q16.16
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 66'sd32768;

    // atan(2^-i) at Q.30, floored
    localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd7,
        32'd3,         32'd1,         32'd0,         32'd0
    };

    // Sine, cosine and busy flag from the CORDIC unit
    typedef struct packed {
        logic                     busy;
        logic signed [TRIG_W-1:0] cosine;
        logic signed [TRIG_W-1:0] sine;
    } se2ta_trig_t;

    // Sign-extend the low w bits of a field to the full field width
    function automatic logic signed [FIELD_W-1:0] sext_low(
        input logic [FIELD_W-1:0] v,
        input int unsigned        w
    );
        logic signed [FIELD_W-1:0] res;
        res = '0;
        for (int unsigned b = 0; b < FIELD_W; b++)
        begin
            res[b] = (b < w) ? v[b] : v[w-1];
        end
        return res;
    endfunction

endpackage

// ===== rtl/se2ta_stream_ifs.sv =====
// se2ta_stream_ifs: valid/ready stream interfaces for input items and results.
// Depends on se2ta_pkg for field widths.
interface se2ta_item_if import se2ta_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           opcode;
    logic signed [FIELD_W-1:0] in_x;
    logic signed [FIELD_W-1:0] in_y;
    logic signed [FIELD_W-1:0] in_omega;

    modport source (output valid, output opcode, output in_x, output in_y,
                    output in_omega, input ready);
    modport sink   (input valid, input opcode, input in_x, input in_y,
                    input in_omega, output ready);
endinterface

interface se2ta_result_if import se2ta_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_omega;
    logic                      saturated;

    modport source (output valid, output out_x, output out_y, output out_omega,
                    output saturated, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_omega,
                    input saturated, output ready);
endinterface

// ===== rtl/se2ta_cordic.sv =====
// se2ta_cordic: iterative rotation-mode CORDIC that turns the angle into cosine
// and sine, one step per cycle, and holds the results. Depends on se2ta_pkg.
module se2ta_cordic import se2ta_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [ANGLE_W-1:0] angle,
    output se2ta_trig_t               trig
);

    typedef enum logic [2:0] {
        C_IDLE   = 3'b001,
        C_ROTATE = 3'b010,
        C_FINISH = 3'b100
    } cordic_state_t;

    cordic_state_t             state_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic signed [XY_W-1:0]    x_reg;
    logic signed [XY_W-1:0]    y_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      neg_reg;
    logic signed [TRIG_W-1:0]  cos_reg;
    logic signed [TRIG_W-1:0]  sin_reg;

    logic signed [Z_W-1:0]     z_start;
    logic signed [Z_W-1:0]     z_reduced;
    logic                      neg_start;
    logic signed [XY_W-1:0]    dx;
    logic signed [XY_W-1:0]    dy;
    logic signed [Z_W-1:0]     atan_step;
    logic signed [XY_W-1:0]    x_next;
    logic signed [XY_W-1:0]    y_next;
    logic signed [Z_W-1:0]     z_next;
    logic signed [XY_W-1:0]    cos_next;
    logic signed [XY_W-1:0]    sin_next;
    logic                      last_step;

    // Double the angle to Q.30 and fold it into -pi/2..pi/2
    always_comb
    begin
        z_start   = Z_W'(angle) <<< 1;
        z_reduced = z_start;
        neg_start = 1'b0;
        if (z_start > Q30_HALF_PI)
        begin
            z_reduced = z_start - Q30_PI;
            neg_start = 1'b1;
        end
        else if (z_start < -Q30_HALF_PI)
        begin
            z_reduced = z_start + Q30_PI;
            neg_start = 1'b1;
        end
    end

    // One micro-rotation, direction from the sign of the residual angle
    always_comb
    begin
        dx        = y_reg >>> step_reg;
        dy        = x_reg >>> step_reg;
        atan_step = Z_W'(ATAN_Q30[step_reg]);
        if (!z_reg[Z_W-1])
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - atan_step;
        end
        else
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + atan_step;
        end
    end

    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    // Undo the fold by negating both results
    assign cos_next = neg_reg ? -x_reg : x_reg;
    assign sin_next = neg_reg ? -y_reg : y_reg;

    // Sequencer and held results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cos_reg   <= COS_ONE;
            sin_reg   <= '0;
        end
        else if (start)
        begin
            state_reg <= C_ROTATE;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    state_reg <= C_IDLE;
                end
                C_ROTATE:
                begin
                    if (last_step)
                    begin
                        state_reg <= C_FINISH;
                    end
                end
                C_FINISH:
                begin
                    cos_reg   <= cos_next[TRIG_W-1:0];
                    sin_reg   <= sin_next[TRIG_W-1:0];
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // Working vector, residual angle and step count
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            z_reg    <= z_reduced;
            neg_reg  <= neg_start;
            x_reg    <= CORDIC_START;
            y_reg    <= '0;
            step_reg <= '0;
        end
        else if (state_reg == C_ROTATE)
        begin
            z_reg    <= z_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign trig.busy   = (state_reg != C_IDLE);
    assign trig.cosine = cos_reg;
    assign trig.sine   = sin_reg;

endmodule

// ===== rtl/se2_transform_apply_top.sv =====
// se2_transform_apply_top: applies a configured planar rigid transform to a stream
// of points, vectors and twists. Depends on se2ta_pkg, the stream interfaces
// and se2ta_cordic.
//
// The block takes one word per cycle while the pipeline can move and the CORDIC unit
// is idle, and returns one result word per input, in order, each passing through the
// stage registers in turn. A stalled output does not stop words entering the empty
// stages behind it. The input register, the products, the rotated and offset terms,
// and the rounded, clipped result each sit in a stage of their own, four stages in all.
// Writing the angle register starts the CORDIC unit, one shift-and-add step per cycle:
// while it runs the input is held off and cosine and sine settle. Offset writes take
// effect at once. Before any angle write the rotation is the identity. Opcode 3
// returns an all-zero result.
module se2_transform_apply_top import se2ta_pkg::*;
#(
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [INDEX_W-1:0]  wr_index,
    input  logic [FIELD_W-1:0]  wr_data,
    se2ta_item_if.sink          items,
    se2ta_result_if.source      results
);

    localparam int CW_IN = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        (ACC_W'(1) <<< (COORD_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic [FIELD_W-1:0] OUT_MASK = (COORD_WIDTH >= FIELD_W) ? '1 :
        FIELD_W'((64'd1 << COORD_WIDTH) - 64'd1);

    se2ta_trig_t trig;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;

    // Configuration
    logic signed [FIELD_W-1:0] offset_x_reg;
    logic signed [FIELD_W-1:0] offset_y_reg;
    logic                      angle_write;

    // Stage valids and readiness
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // Stage 1: registered input word
    logic [OP_W-1:0]           op1_reg;
    logic signed [FIELD_W-1:0] x1_reg;
    logic signed [FIELD_W-1:0] y1_reg;
    logic signed [FIELD_W-1:0] w1_reg;
    logic [FIELD_W-1:0]        omega1_reg;

    // Stage 2: products
    logic [OP_W-1:0]           op2_reg;
    logic signed [PROD_W-1:0]  xc2_reg, ys2_reg, xs2_reg, yc2_reg, wy2_reg, wx2_reg;
    logic [FIELD_W-1:0]        omega2_reg;

    // Stage 3: rotated terms and biased offset terms
    logic [OP_W-1:0]           op3_reg;
    logic signed [ACC_W-1:0]   rot_x_reg, rot_y_reg, term_x_reg, term_y_reg;
    logic [FIELD_W-1:0]        omega3_reg;
    logic signed [ACC_W-1:0]   rot_x_next, rot_y_next, term_x_next, term_y_next;

    // Stage 4: result
    logic [FIELD_W-1:0]        out_x_reg, out_y_reg, out_omega_reg;
    logic                      sat_reg;
    logic signed [ACC_W-1:0]   acc_x, acc_y, rnd_x, rnd_y, clip_x, clip_y;
    logic                      hi_x, lo_x, hi_y, lo_y;
    logic [FIELD_W-1:0]        out_x_next, out_y_next, out_omega_next;
    logic                      sat_next;

    // Sine and cosine source
    assign angle_write = wr_en && (wr_index == REG_ANGLE);

    se2ta_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (angle_write),
        .angle (wr_data),
        .trig  (trig)
    );

    assign cos_val = trig.cosine;
    assign sin_val = trig.sine;

    // Offset registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_OFFSET_X: offset_x_reg <= sext_low(wr_data, CW_IN);
                REG_OFFSET_Y: offset_y_reg <= sext_low(wr_data, CW_IN);
                default:      ;
            endcase
        end
    end

    // Advance a stage when it is empty or the stage after it moves
    assign rdy4 = !v4_reg || results.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign items.ready = rdy1 && !trig.busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= items.valid && items.ready;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Capture the input word, coordinates narrowed to the coordinate width
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            op1_reg    <= items.opcode;
            x1_reg     <= sext_low(items.in_x, CW_IN);
            y1_reg     <= sext_low(items.in_y, CW_IN);
            w1_reg     <= sext_low(items.in_omega, CW_IN);
            omega1_reg <= items.in_omega;
        end
    end

    // Multiply by cosine, sine and the offsets
    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            op2_reg    <= op1_reg;
            xc2_reg    <= PROD_W'(x1_reg) * PROD_W'(cos_val);
            ys2_reg    <= PROD_W'(y1_reg) * PROD_W'(sin_val);
            xs2_reg    <= PROD_W'(x1_reg) * PROD_W'(sin_val);
            yc2_reg    <= PROD_W'(y1_reg) * PROD_W'(cos_val);
            wy2_reg    <= PROD_W'(w1_reg) * PROD_W'(offset_y_reg);
            wx2_reg    <= PROD_W'(w1_reg) * PROD_W'(offset_x_reg);
            omega2_reg <= omega1_reg;
        end
    end

    // Form the rotated terms at Q.32 and pick the offset term, rounding bias included
    always_comb
    begin
        rot_x_next = (ACC_W'(xc2_reg) - ACC_W'(ys2_reg)) >>> 14;
        rot_y_next = (ACC_W'(xs2_reg) + ACC_W'(yc2_reg)) >>> 14;
        case (op2_reg)
            OP_POINT:
            begin
                term_x_next = (ACC_W'(offset_x_reg) <<< 16) + ROUND_HALF;
                term_y_next = (ACC_W'(offset_y_reg) <<< 16) + ROUND_HALF;
            end
            OP_TWIST:
            begin
                term_x_next = ACC_W'(wy2_reg) + ROUND_HALF;
                term_y_next = ROUND_HALF - ACC_W'(wx2_reg);
            end
            default:
            begin
                term_x_next = ROUND_HALF;
                term_y_next = ROUND_HALF;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            op3_reg    <= op2_reg;
            rot_x_reg  <= rot_x_next;
            rot_y_reg  <= rot_y_next;
            term_x_reg <= term_x_next;
            term_y_reg <= term_y_next;
            omega3_reg <= omega2_reg;
        end
    end

    // Sum, round to Q16.16 and clip to the coordinate range
    always_comb
    begin
        acc_x  = rot_x_reg + term_x_reg;
        acc_y  = rot_y_reg + term_y_reg;
        rnd_x  = acc_x >>> 16;
        rnd_y  = acc_y >>> 16;
        hi_x   = rnd_x > SAT_HI;
        lo_x   = rnd_x < SAT_LO;
        hi_y   = rnd_y > SAT_HI;
        lo_y   = rnd_y < SAT_LO;
        clip_x = hi_x ? SAT_HI : (lo_x ? SAT_LO : rnd_x);
        clip_y = hi_y ? SAT_HI : (lo_y ? SAT_LO : rnd_y);
        if (op3_reg == OP_RESERVED)
        begin
            out_x_next     = '0;
            out_y_next     = '0;
            out_omega_next = '0;
            sat_next       = 1'b0;
        end
        else
        begin
            out_x_next     = clip_x[FIELD_W-1:0] & OUT_MASK;
            out_y_next     = clip_y[FIELD_W-1:0] & OUT_MASK;
            out_omega_next = (op3_reg == OP_TWIST) ? omega3_reg : '0;
            sat_next       = hi_x || lo_x || hi_y || lo_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_omega_reg <= out_omega_next;
            sat_reg       <= sat_next;
        end
    end

    assign results.valid     = v4_reg;
    assign results.out_x     = out_x_reg;
    assign results.out_y     = out_y_reg;
    assign results.out_omega = out_omega_reg;
    assign results.saturated = sat_reg;

endmodule

// ===== tb/se2_transform_apply_top_test.sv =====
// Self-checking testbench for se2_transform_apply_top: planar rotation, offset and twist
// mapping, checked word by word against a cycle-free predictor with its own CORDIC.
// Depends on se2ta_pkg, the stream interfaces and the block's RTL.
module se2_transform_apply_top_test import se2ta_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int STEPS          = DEF_CORDIC_STEPS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 12;
    localparam int RANDOM_PHASES  = 15;
    localparam int PHASE_WORDS    = 100;
    localparam int PRESSURE_HOLD  = 300;
    localparam int PRESSURE_WORDS = 80;

    // Index with no register behind it
    localparam logic [INDEX_W-1:0] REG_NONE = 2'd3;

    // Angle constants: Q.30 for the CORDIC, Q3.29 for the register
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_START  = 64'sd652032874;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint PI_Q29      = 64'sd1686629713;

    typedef logic signed [FIELD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t omega;
        logic   clipped;
    } transform_word_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [INDEX_W-1:0] wr_index;
    logic [FIELD_W-1:0] wr_data;

    se2ta_item_if   item_ch ();
    se2ta_result_if result_ch ();

    se2_transform_apply_top #(
        .COORD_WIDTH  (DEF_COORD_WIDTH),
        .CORDIC_STEPS (STEPS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .items    (item_ch),
        .results  (result_ch)
    );

    // Predictor state: configured transform and held trig values
    coord_t angle_cfg;
    coord_t offset_x_cfg;
    coord_t offset_y_cfg;
    longint rot_cos;
    longint rot_sin;

    transform_word_t pending_results[$];
    int error_count;
    int send_gap_max;
    int recv_gap_max;
    int result_hold_request;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // arctan(2^-i) at Q.30, floored
    function automatic longint atan_step(input int i);
        case (i)
            0:  return 843314856;
            1:  return 497837829;
            2:  return 263043836;
            3:  return 133525158;
            4:  return 67021686;
            5:  return 33543515;
            6:  return 16775850;
            7:  return 8388437;
            8:  return 4194282;
            9:  return 2097149;
            10: return 1048575;
            11: return 524287;
            12: return 262143;
            13: return 131071;
            14: return 65535;
            15: return 32767;
            16: return 16383;
            17: return 8191;
            18: return 4095;
            19: return 2047;
            20: return 1023;
            21: return 511;
            22: return 255;
            23: return 127;
            24: return 63;
            25: return 31;
            26: return 15;
            27: return 7;
            28: return 3;
            29: return 1;
            default: return 0;
        endcase
    endfunction

    // Rotate the start vector through the configured angle; fold outside +-pi/2
    function automatic void update_trig();
        longint z;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        bit     flip;
        z    = longint'(angle_cfg) * 2;
        cx   = GAIN_START;
        cy   = 0;
        flip = 1'b0;
        if (z > HALF_PI_Q30)
        begin
            z    = z - PI_Q30;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_Q30)
        begin
            z    = z + PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS && i < 32; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0)
            begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - atan_step(i);
            end
            else
            begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + atan_step(i);
            end
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        rot_cos = cx;
        rot_sin = cy;
    endfunction

    function automatic void reset_transform();
        angle_cfg    = '0;
        offset_x_cfg = '0;
        offset_y_cfg = '0;
        rot_cos      = ONE_Q30;
        rot_sin      = 0;
    endfunction

    function automatic void apply_register(input logic [INDEX_W-1:0] idx,
                                           input logic [FIELD_W-1:0] data);
        case (idx)
            REG_ANGLE:
            begin
                angle_cfg = data;
                update_trig();
            end
            REG_OFFSET_X: offset_x_cfg = data;
            REG_OFFSET_Y: offset_y_cfg = data;
            default: ;
        endcase
    endfunction

    // Round Q.32 to Q16.16 with ties upward, then clip to the coordinate range
    function automatic coord_t round_clip(input longint acc, inout bit clip);
        longint r;
        r = (acc + 32768) >>> 16;
        if (r > longint'(COORD_MAX))
        begin
            clip = 1'b1;
            return COORD_MAX;
        end
        if (r < longint'(COORD_MIN))
        begin
            clip = 1'b1;
            return COORD_MIN;
        end
        return coord_t'(r);
    endfunction

    function automatic transform_word_t predict_transform(input logic [OP_W-1:0] op,
                                                          input coord_t x,
                                                          input coord_t y,
                                                          input coord_t w);
        transform_word_t res;
        longint ax;
        longint ay;
        bit     clip;
        res  = '0;
        clip = 1'b0;
        if (op == OP_RESERVED)
            return res;
        ax = (longint'(x) * rot_cos - longint'(y) * rot_sin) >>> 14;
        ay = (longint'(x) * rot_sin + longint'(y) * rot_cos) >>> 14;
        if (op == OP_POINT)
        begin
            ax = ax + longint'(offset_x_cfg) * 65536;
            ay = ay + longint'(offset_y_cfg) * 65536;
        end
        else if (op == OP_TWIST)
        begin
            ax = ax + longint'(w) * longint'(offset_y_cfg);
            ay = ay - longint'(w) * longint'(offset_x_cfg);
        end
        res.x       = round_clip(ax, clip);
        res.y       = round_clip(ay, clip);
        res.omega   = (op == OP_TWIST) ? w : '0;
        res.clipped = clip;
        return res;
    endfunction

    // Offer one word after a random gap, hold it until accepted, record its result
    task automatic send_item(input logic [OP_W-1:0] op, input coord_t x, input coord_t y,
                             input coord_t w);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.opcode   <= op;
        item_ch.in_x     <= x;
        item_ch.in_y     <= y;
        item_ch.in_omega <= w;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_transform(op, x, y, w));
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [FIELD_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        apply_register(idx, data);
    endtask

    // Drop valid, drain the pipeline, and let any CORDIC run finish before writes
    task automatic drain_for_config();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (STEPS + 2) @(posedge clk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return coord_t'($urandom);
            default: return coord_t'(longint'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] rand_opcode();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4:   return OP_POINT;
            5, 6, 7, 8, 9:   return OP_VECTOR;
            10, 11, 12, 13, 14: return OP_TWIST;
            default:         return OP_RESERVED;
        endcase
    endfunction

    function automatic coord_t rand_angle();
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return coord_t'(PI_Q29);
                    1: return coord_t'(-PI_Q29);
                    2: return COORD_MAX;
                    3: return COORD_MIN;
                    default: return '0;
                endcase
            end
            1: return coord_t'($urandom);
            default: return coord_t'(longint'($urandom_range(0, 32'd3373259426)) - PI_Q29);
        endcase
    endfunction

    function automatic coord_t rand_offset();
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1: return coord_t'($urandom);
            default: return coord_t'(longint'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
        endcase
    endfunction

    // Identity rotation straight out of reset, every opcode, field extremes
    task automatic test_reset_identity();
        send_gap_max = 0;
        recv_gap_max = 0;
        send_item(OP_POINT, COORD_MAX, COORD_MIN, 32'sh0000_1234);
        send_item(OP_VECTOR, '1, 32'sh0001_0000, COORD_MAX);
        send_item(OP_TWIST, 32'sh0003_8000, COORD_MIN, COORD_MAX);
        send_item(OP_RESERVED, COORD_MAX, COORD_MAX, COORD_MIN);
    endtask

    // Offset writes alone keep the identity rotation; saturation and rounding ties
    task automatic test_offsets_keep_trig();
        drain_for_config();
        write_reg(REG_OFFSET_X, COORD_MAX);
        write_reg(REG_OFFSET_Y, COORD_MIN);
        send_gap_max = 2;
        recv_gap_max = 2;
        send_item(OP_POINT, COORD_MAX, COORD_MAX, '0);
        send_item(OP_POINT, COORD_MIN, COORD_MIN, '0);
        drain_for_config();
        write_reg(REG_OFFSET_X, 32'sh0000_8000);
        write_reg(REG_OFFSET_Y, 32'sh0000_8000);
        // Write to the unused index must change nothing
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        send_item(OP_TWIST, 32'sh0002_0000, 32'sh0005_0000, 32'sh0000_0001);
        send_item(OP_TWIST, 32'shFFFD_0000, 32'sh0000_0000, 32'shFFFF_FFFF);
        send_item(OP_VECTOR, 32'sh0000_3039, 32'shFFFF_E57B, '0);
    endtask

    // Angles at and past +-pi, zero and a quarter turn
    task automatic test_angle_extremes();
        coord_t angles[6];
        angles[0] = coord_t'(PI_Q29);
        angles[1] = coord_t'(-PI_Q29);
        angles[2] = '0;
        angles[3] = COORD_MAX;
        angles[4] = COORD_MIN;
        angles[5] = coord_t'(PI_Q29 / 2);
        send_gap_max = 1;
        recv_gap_max = 1;
        drain_for_config();
        write_reg(REG_OFFSET_X, 32'sh0005_0000);
        write_reg(REG_OFFSET_Y, 32'shFFFD_0000);
        foreach (angles[i])
        begin
            drain_for_config();
            write_reg(REG_ANGLE, angles[i]);
            send_item(OP_POINT, 32'sh000A_0000, 32'shFFFC_8000, '0);
            send_item(OP_TWIST, COORD_MAX, COORD_MIN, 32'sh0001_8000);
        end
    endtask

    // Random settings per phase, mixed idling, stretches with none
    task automatic test_random_phases();
        logic [OP_W-1:0] op;
        coord_t x;
        coord_t y;
        coord_t w;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_for_config();
            write_reg(REG_OFFSET_X, rand_offset());
            write_reg(REG_OFFSET_Y, rand_offset());
            if ($urandom_range(0, 4) != 0)
                write_reg(REG_ANGLE, rand_angle());
            send_gap_max = (p % 4 == 1 || p % 4 == 3) ? 4 : 0;
            recv_gap_max = (p % 4 == 2 || p % 4 == 3) ? 4 : 0;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                op = rand_opcode();
                x  = rand_coord();
                y  = rand_coord();
                w  = rand_coord();
                send_item(op, x, y, w);
            end
        end
    endtask

    // Hold the output off while the input keeps offering, so the pipe fills and stalls
    task automatic test_backpressure();
        drain_for_config();
        write_reg(REG_ANGLE, rand_angle());
        send_gap_max        = 0;
        recv_gap_max        = 0;
        result_hold_request = PRESSURE_HOLD;
        for (int n = 0; n < PRESSURE_WORDS; n++)
            send_item(rand_opcode(), rand_coord(), rand_coord(), rand_coord());
    endtask

    // Stimulus and end of run
    initial
    begin
        rst_n            <= 1'b0;
        wr_en            <= 1'b0;
        wr_index         <= REG_ANGLE;
        wr_data          <= '0;
        item_ch.valid    <= 1'b0;
        item_ch.opcode   <= OP_POINT;
        item_ch.in_x     <= '0;
        item_ch.in_y     <= '0;
        item_ch.in_omega <= '0;
        error_count         = 0;
        send_gap_max        = 0;
        recv_gap_max        = 0;
        result_hold_request = 0;
        reset_transform();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_identity();
        test_offsets_keep_trig();
        test_angle_extremes();
        test_random_phases();
        test_backpressure();

        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stalls, long hold on request, check each word taken
    initial
    begin
        int stall;
        int hold;
        transform_word_t exp_w;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, recv_gap_max);
            if (result_hold_request > 0)
            begin
                hold                = result_hold_request;
                result_hold_request = 0;
                stall               = stall + hold;
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing pending: out_x %0d out_y %0d",
                       result_ch.out_x, result_ch.out_y);
                error_count++;
            end
            else
            begin
                exp_w = pending_results.pop_front();
                if (result_ch.out_x !== exp_w.x)
                begin
                    $error("out_x: expected %0d, got %0d", exp_w.x, result_ch.out_x);
                    error_count++;
                end
                if (result_ch.out_y !== exp_w.y)
                begin
                    $error("out_y: expected %0d, got %0d", exp_w.y, result_ch.out_y);
                    error_count++;
                end
                if (result_ch.out_omega !== exp_w.omega)
                begin
                    $error("out_omega: expected %0d, got %0d", exp_w.omega,
                           result_ch.out_omega);
                    error_count++;
                end
                if (result_ch.saturated !== exp_w.clipped)
                begin
                    $error("saturated: expected %0b, got %0b", exp_w.clipped,
                           result_ch.saturated);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
